>>> rtl/pid_quad_motor_mixer_defines.svh
// Assertion macros used by the checker file.
`ifndef PID_QUAD_MOTOR_MIXER_DEFINES_SVH
`define PID_QUAD_MOTOR_MIXER_DEFINES_SVH

// Same-cycle implication, reset masks the check
`define PQMM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pqmm assertion failed");

// Next-cycle implication, reset masks the check
`define PQMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pqmm assertion failed");

`endif

>>> rtl/pqmm_pkg.sv
package pqmm_pkg;

  // Fixed-point widths
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned ERR_W      = 16;
  localparam int unsigned ISUM_W     = 32;
  localparam int unsigned DIFF_W     = ERR_W + 1;
  localparam int unsigned PULSE_W    = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = GAIN_W;
  localparam int unsigned PROD_P_W   = GAIN_W + ERR_W + 1;
  localparam int unsigned PROD_I_W   = GAIN_W + ISUM_W + 1;
  localparam int unsigned PROD_D_W   = GAIN_W + DIFF_W + 1;
  localparam int unsigned ACC_W      = PROD_I_W + 1;
  localparam int unsigned FRAC_SHIFT = 30;
  localparam int unsigned PTERM_W    = ACC_W - FRAC_SHIFT;
  localparam int unsigned MIX_W      = PTERM_W + 2;

  // Register reset values
  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN  = 24'd32768;
  localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN = 24'd2163;
  localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN = 24'd3932160;
  localparam logic [PULSE_W-1:0] RST_PULSE_MIN  = 12'd1000;
  localparam logic [PULSE_W-1:0] RST_PULSE_MAX  = 12'd1500;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_PULSE_MIN  = 3'd3,
    REG_PULSE_MAX  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [ERR_W-1:0]   pitch_error;
    logic        [PULSE_W-1:0] throttle_us;
    logic signed [PULSE_W-1:0] roll_term;
    logic signed [PULSE_W-1:0] yaw_term;
  } in_item_t;

  typedef struct packed {
    logic [PULSE_W-1:0] motor_one;
    logic [PULSE_W-1:0] motor_two;
    logic [PULSE_W-1:0] motor_three;
    logic [PULSE_W-1:0] motor_four;
  } out_item_t;

  // Lower bound first, then upper bound
  function automatic logic [PULSE_W-1:0] clamp_pulse(
    input logic signed [MIX_W-1:0] v,
    input logic        [PULSE_W-1:0] lo,
    input logic        [PULSE_W-1:0] hi
  );
    logic signed [MIX_W-1:0] r;
    logic signed [MIX_W-1:0] lo_x;
    logic signed [MIX_W-1:0] hi_x;
    lo_x = $signed(MIX_W'(lo));
    hi_x = $signed(MIX_W'(hi));
    r    = v;
    if (r < lo_x) r = lo_x;
    if (r > hi_x) r = hi_x;
    return r[PULSE_W-1:0];
  endfunction

endpackage

>>> rtl/pqmm_mix.sv
// Sums the three PID products, scales to microseconds and mixes the
// four motor pulse widths with clamping.
module pqmm_mix (
  input  logic signed [pqmm_pkg::PROD_P_W-1:0] prod_p_i,
  input  logic signed [pqmm_pkg::PROD_I_W-1:0] prod_i_i,
  input  logic signed [pqmm_pkg::PROD_D_W-1:0] prod_d_i,
  input  logic        [pqmm_pkg::PULSE_W-1:0]  throttle_i,
  input  logic signed [pqmm_pkg::PULSE_W-1:0]  roll_i,
  input  logic signed [pqmm_pkg::PULSE_W-1:0]  yaw_i,
  input  logic        [pqmm_pkg::PULSE_W-1:0]  pulse_min_i,
  input  logic        [pqmm_pkg::PULSE_W-1:0]  pulse_max_i,
  output pqmm_pkg::out_item_t                  motors_o
);

  logic signed [pqmm_pkg::ACC_W-1:0]   acc;
  logic signed [pqmm_pkg::PTERM_W-1:0] pterm;
  logic signed [pqmm_pkg::MIX_W-1:0]   thr_x, p_x, roll_x, yaw_x;
  logic signed [pqmm_pkg::MIX_W-1:0]   mix_one, mix_two, mix_three, mix_four;

  // Exact PID sum; arithmetic shift floors toward minus infinity
  assign acc = pqmm_pkg::ACC_W'(prod_p_i) + pqmm_pkg::ACC_W'(prod_i_i)
             + pqmm_pkg::ACC_W'(prod_d_i);
  assign pterm = acc[pqmm_pkg::ACC_W-1:pqmm_pkg::FRAC_SHIFT];

  assign thr_x  = $signed(pqmm_pkg::MIX_W'(throttle_i));
  assign p_x    = pqmm_pkg::MIX_W'(pterm);
  assign roll_x = pqmm_pkg::MIX_W'(roll_i);
  assign yaw_x  = pqmm_pkg::MIX_W'(yaw_i);

  // X-frame mix
  assign mix_one   = thr_x - p_x - roll_x - yaw_x;
  assign mix_two   = thr_x - p_x + roll_x + yaw_x;
  assign mix_three = thr_x + p_x + roll_x - yaw_x;
  assign mix_four  = thr_x + p_x - roll_x + yaw_x;

  assign motors_o.motor_one   = pqmm_pkg::clamp_pulse(mix_one,   pulse_min_i, pulse_max_i);
  assign motors_o.motor_two   = pqmm_pkg::clamp_pulse(mix_two,   pulse_min_i, pulse_max_i);
  assign motors_o.motor_three = pqmm_pkg::clamp_pulse(mix_three, pulse_min_i, pulse_max_i);
  assign motors_o.motor_four  = pqmm_pkg::clamp_pulse(mix_four,  pulse_min_i, pulse_max_i);

endmodule

>>> rtl/pid_quad_motor_mixer.sv
// Pitch PID controller with quadcopter X mixer. Takes one item per clock
// while in_stall_o is low and returns one set of four motor pulse widths
// per item once it has passed all three registers below. The integral and
// previous-error state update at the input transfer itself, so successive
// items need no gap. The pipeline is input register, product register
// (three gain multiplies) and result register; a stall at the output holds
// all three and pushes back to the input only once every stage is full.
// Gains and pulse limits are written through the configuration port, which
// is always ready; write them only while no item is in flight.
module pid_quad_motor_mixer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pqmm_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pqmm_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pqmm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pqmm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // Configuration registers
  logic [pqmm_pkg::GAIN_W-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [pqmm_pkg::PULSE_W-1:0] pulse_min_q, pulse_max_q;

  // Controller state
  logic signed [pqmm_pkg::ISUM_W-1:0] error_sum_q, error_sum_d;
  logic signed [pqmm_pkg::ERR_W-1:0]  prev_error_q;

  // Stage one: error terms and mixer inputs
  logic                                s1_valid_q;
  logic signed [pqmm_pkg::ERR_W-1:0]   s1_err_q;
  logic signed [pqmm_pkg::ISUM_W-1:0]  s1_isum_q;
  logic signed [pqmm_pkg::DIFF_W-1:0]  s1_diff_q, s1_diff_d;
  logic        [pqmm_pkg::PULSE_W-1:0] s1_thr_q;
  logic signed [pqmm_pkg::PULSE_W-1:0] s1_roll_q, s1_yaw_q;

  // Stage two: products
  logic                                 s2_valid_q;
  logic signed [pqmm_pkg::PROD_P_W-1:0] s2_prod_p_q, s2_prod_p_d;
  logic signed [pqmm_pkg::PROD_I_W-1:0] s2_prod_i_q, s2_prod_i_d;
  logic signed [pqmm_pkg::PROD_D_W-1:0] s2_prod_d_q, s2_prod_d_d;
  logic        [pqmm_pkg::PULSE_W-1:0]  s2_thr_q;
  logic signed [pqmm_pkg::PULSE_W-1:0]  s2_roll_q, s2_yaw_q;

  // Result register
  logic                out_valid_q;
  pqmm_pkg::out_item_t out_data_q, out_data_d;

  logic out_adv, s2_adv, s1_adv, in_xfer;
  logic signed [pqmm_pkg::ISUM_W:0] isum_wide;

  // Pipeline advance: a stage loads when empty or when its successor loads
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s2_adv     = !s2_valid_q || out_adv;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;
  assign in_xfer    = in_valid_i && s1_adv;

  assign cfg_ready_o = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= pqmm_pkg::RST_PROP_GAIN;
      integ_gain_q <= pqmm_pkg::RST_INTEG_GAIN;
      deriv_gain_q <= pqmm_pkg::RST_DERIV_GAIN;
      pulse_min_q  <= pqmm_pkg::RST_PULSE_MIN;
      pulse_max_q  <= pqmm_pkg::RST_PULSE_MAX;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pqmm_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data_i;
        pqmm_pkg::REG_INTEG_GAIN: integ_gain_q <= cfg_data_i;
        pqmm_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data_i;
        pqmm_pkg::REG_PULSE_MIN:  pulse_min_q  <= cfg_data_i[pqmm_pkg::PULSE_W-1:0];
        pqmm_pkg::REG_PULSE_MAX:  pulse_max_q  <= cfg_data_i[pqmm_pkg::PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturating integral and error difference
  always_comb begin
    isum_wide = (pqmm_pkg::ISUM_W + 1)'(error_sum_q)
              + (pqmm_pkg::ISUM_W + 1)'(in_data_i.pitch_error);
    if (isum_wide[pqmm_pkg::ISUM_W] != isum_wide[pqmm_pkg::ISUM_W-1]) begin
      error_sum_d = isum_wide[pqmm_pkg::ISUM_W]
                  ? {1'b1, {(pqmm_pkg::ISUM_W-1){1'b0}}}
                  : {1'b0, {(pqmm_pkg::ISUM_W-1){1'b1}}};
    end else begin
      error_sum_d = isum_wide[pqmm_pkg::ISUM_W-1:0];
    end
    s1_diff_d = pqmm_pkg::DIFF_W'(in_data_i.pitch_error)
              - pqmm_pkg::DIFF_W'(prev_error_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= '0;
      prev_error_q <= '0;
    end else if (in_xfer) begin
      error_sum_q  <= error_sum_d;
      prev_error_q <= in_data_i.pitch_error;
    end
  end

  // Stage one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_err_q  <= in_data_i.pitch_error;
      s1_isum_q <= error_sum_d;
      s1_diff_q <= s1_diff_d;
      s1_thr_q  <= in_data_i.throttle_us;
      s1_roll_q <= in_data_i.roll_term;
      s1_yaw_q  <= in_data_i.yaw_term;
    end
  end

  // Gain multiplies, gains zero-extended to signed
  assign s2_prod_p_d = pqmm_pkg::PROD_P_W'($signed({1'b0, prop_gain_q}))
                     * pqmm_pkg::PROD_P_W'(s1_err_q);
  assign s2_prod_i_d = pqmm_pkg::PROD_I_W'($signed({1'b0, integ_gain_q}))
                     * pqmm_pkg::PROD_I_W'(s1_isum_q);
  assign s2_prod_d_d = pqmm_pkg::PROD_D_W'($signed({1'b0, deriv_gain_q}))
                     * pqmm_pkg::PROD_D_W'(s1_diff_q);

  // Stage two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_adv) begin
      s2_prod_p_q <= s2_prod_p_d;
      s2_prod_i_q <= s2_prod_i_d;
      s2_prod_d_q <= s2_prod_d_d;
      s2_thr_q    <= s1_thr_q;
      s2_roll_q   <= s1_roll_q;
      s2_yaw_q    <= s1_yaw_q;
    end
  end

  pqmm_mix u_mix (
    .prod_p_i    (s2_prod_p_q),
    .prod_i_i    (s2_prod_i_q),
    .prod_d_i    (s2_prod_d_q),
    .throttle_i  (s2_thr_q),
    .roll_i      (s2_roll_q),
    .yaw_i       (s2_yaw_q),
    .pulse_min_i (pulse_min_q),
    .pulse_max_i (pulse_max_q),
    .motors_o    (out_data_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && out_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/pqmm_checker.sv
`include "pid_quad_motor_mixer_defines.svh"

// Port-level checks on the mixer: occupancy, configuration ready and output hold.
module pqmm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input pqmm_pkg::in_item_t              in_data_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input pqmm_pkg::out_item_t             out_data_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [pqmm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [pqmm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [2:0] MAX_FILL = 3'd3;

  logic [2:0] fill_q, fill_d;
  logic       in_xfer, out_xfer;
  logic       unused_ok;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_xfer  = out_valid_o && !out_stall_i;
  assign unused_ok = cfg_valid_i ^ (|cfg_index_i) ^ (|cfg_data_i) ^ (|in_data_i);

  // Items accepted but not yet delivered
  always_comb begin
    fill_d = fill_q;
    if (in_xfer && !out_xfer) fill_d = fill_q + 3'd1;
    if (!in_xfer && out_xfer) fill_d = fill_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  `PQMM_ASSERT_IMPL(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_o || unused_ok)
  `PQMM_ASSERT_IMPL(a_no_phantom_result, clk_i, rst_ni, out_valid_o, fill_q != 3'd0)
  `PQMM_ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= MAX_FILL)
  `PQMM_ASSERT_IMPL(a_empty_no_stall, clk_i, rst_ni, fill_q == 3'd0, !in_stall_o)
  `PQMM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_data_o))

endmodule

bind pid_quad_motor_mixer pqmm_checker u_pqmm_checker (.*);
